/* rtl/core/ssfe_pkg.sv */
package ssfe_pkg;

  // Radius register and its derived squares.
  localparam int RADIUS_W = 15;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int R4_W     = 2 * R2_W;

  // Quotient widths of the two dividers.
  localparam int DIST_Q_W  = 31;
  localparam int FIELD_Q_W = 17;

  // Output format: unsigned Q0.16.
  localparam int FIELD_W    = 16;
  localparam int FIELD_FRAC = 16;

  // Register stages of the geometry front end and of the falloff stage.
  localparam int GEOM_LAT = 6;
  localparam int FALL_LAT = 2;

  // Accept edge to the edge that takes the result.
  localparam int PIPE_LAT = GEOM_LAT + DIST_Q_W + FALL_LAT + FIELD_Q_W + 1;

  typedef enum logic [2:0] {
    REG_END_A_X = 3'd0,
    REG_END_A_Y = 3'd1,
    REG_END_A_Z = 3'd2,
    REG_END_B_X = 3'd3,
    REG_END_B_Y = 3'd4,
    REG_END_B_Z = 3'd5,
    REG_RADIUS  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic perp;
    logic ovf;
  } geom_flags_t;

endpackage

/* rtl/core/ssfe_div_pipe.sv */
module ssfe_div_pipe #(
  parameter int NUM_W  = 72,
  parameter int DEN_W  = 36,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 38
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  // One quotient bit per stage, most significant first.
  logic [RW-1:0]     rem  [Q_W];
  logic [DEN_W-1:0]  dv   [Q_W];
  logic [Q_W-1:0]    qv   [Q_W];
  logic [SIDE_W-1:0] sv   [Q_W];
  logic              vld  [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     den_sh;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    q_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    logic              take;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(num);
      assign den_in  = den;
      assign q_in    = '0;
      assign side_in = side;
      assign v_in    = in_valid;
    end else begin : g_rest
      assign rem_in  = rem[s-1];
      assign den_in  = dv[s-1];
      assign q_in    = qv[s-1];
      assign side_in = sv[s-1];
      assign v_in    = vld[s-1];
    end

    assign den_sh = RW'(den_in) << (Q_W - 1 - s);
    assign take   = (rem_in >= den_sh);

    always_ff @(posedge clk) begin
      rem[s] <= take ? (rem_in - den_sh) : rem_in;
      dv[s]  <= den_in;
      qv[s]  <= take ? (q_in | (Q_W'(1) << (Q_W - 1 - s))) : q_in;
      sv[s]  <= side_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = qv[Q_W-1];
  assign out_side  = sv[Q_W-1];

endmodule

/* rtl/core/ssfe_geom.sv */
module ssfe_geom #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] pz,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] bz,
  output logic                          out_valid,
  output logic [4*COORD_WIDTH+7:0]      out_csq,
  output logic [2*COORD_WIDTH+3:0]      out_len2,
  output logic [2*COORD_WIDTH+3:0]      out_ep,
  output ssfe_pkg::geom_flags_t         out_flags
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * W + 4;
  localparam int CW = 2 * W + 3;
  localparam int QW = 2 * CW;
  localparam int NW = 4 * W + 8;
  localparam int OW = (NW > SW + ssfe_pkg::DIST_Q_W) ? NW : SW + ssfe_pkg::DIST_Q_W;

  logic signed [W-1:0] p [3];
  logic signed [W-1:0] a [3];
  logic signed [W-1:0] b [3];

  assign p[0] = px;
  assign p[1] = py;
  assign p[2] = pz;
  assign a[0] = ax;
  assign a[1] = ay;
  assign a[2] = az;
  assign b[0] = bx;
  assign b[1] = by;
  assign b[2] = bz;

  // Segment direction and squared length follow the endpoint registers.
  logic signed [DW-1:0] d   [3];
  logic signed [PW-1:0] dsq [3];
  logic [SW-1:0]        len2;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d[k]   <= DW'(b[k]) - DW'(a[k]);
      dsq[k] <= PW'(d[k]) * PW'(d[k]);
    end
    len2 <= SW'(dsq[0]) + SW'(dsq[1]) + SW'(dsq[2]);
  end

  // Stage 0: offsets from both endpoints.
  logic signed [DW-1:0] ap [3];
  logic signed [DW-1:0] bp [3];
  logic                 v0;

  // Stage 1: all products.
  logic signed [PW-1:0] pr  [3][3];
  logic signed [PW-1:0] sqa [3];
  logic signed [PW-1:0] sqb [3];
  logic                 v1;

  // Stage 2: dot product, cross product, endpoint distances.
  logic signed [SW-1:0] dot;
  logic signed [CW-1:0] cr [3];
  logic [SW-1:0]        sa2;
  logic [SW-1:0]        sb2;
  logic                 v2;

  // Stage 3: squared cross terms and classification.
  logic signed [QW-1:0] csqk [3];
  logic                 zl3;
  logic                 before3;
  logic                 after3;
  logic [SW-1:0]        sa3;
  logic [SW-1:0]        sb3;
  logic                 v3;

  // Stage 4: cross product magnitude squared, endpoint choice.
  logic [NW-1:0] csq4;
  logic          perp4;
  logic [SW-1:0] ep4;
  logic          v4;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ap[k] <= DW'(p[k]) - DW'(a[k]);
      bp[k] <= DW'(p[k]) - DW'(b[k]);
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr[i][j] <= PW'(ap[i]) * PW'(d[j]);
      end
      sqa[i] <= PW'(ap[i]) * PW'(ap[i]);
      sqb[i] <= PW'(bp[i]) * PW'(bp[i]);
    end

    dot   <= SW'(pr[0][0]) + SW'(pr[1][1]) + SW'(pr[2][2]);
    cr[0] <= CW'(pr[1][2]) - CW'(pr[2][1]);
    cr[1] <= CW'(pr[2][0]) - CW'(pr[0][2]);
    cr[2] <= CW'(pr[0][1]) - CW'(pr[1][0]);
    sa2   <= SW'(sqa[0]) + SW'(sqa[1]) + SW'(sqa[2]);
    sb2   <= SW'(sqb[0]) + SW'(sqb[1]) + SW'(sqb[2]);

    for (int k = 0; k < 3; k++) begin
      csqk[k] <= QW'(cr[k]) * QW'(cr[k]);
    end
    zl3     <= (len2 == '0);
    before3 <= dot[SW-1];
    after3  <= ($signed({dot[SW-1], dot}) > $signed({1'b0, len2}));
    sa3     <= sa2;
    sb3     <= sb2;

    csq4  <= NW'(csqk[0]) + NW'(csqk[1]) + NW'(csqk[2]);
    perp4 <= !(zl3 || before3 || after3);
    ep4   <= (zl3 || before3) ? sa3 : sb3;

    out_csq        <= csq4;
    out_ep         <= ep4;
    out_flags.perp <= perp4;
    out_flags.ovf  <= perp4 && (OW'(csq4) >= (OW'(len2) << ssfe_pkg::DIST_Q_W));
  end

  assign out_len2 = len2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

/* rtl/core/ssfe_falloff.sv */
module ssfe_falloff #(
  parameter int EP_W = 36
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ssfe_pkg::DIST_Q_W-1:0] quot,
  input  ssfe_pkg::geom_flags_t         flags,
  input  logic [EP_W-1:0]               ep,
  input  logic [ssfe_pkg::R2_W-1:0]     r2,
  output logic                          out_valid,
  output logic [ssfe_pkg::R4_W-1:0]     dd_sq,
  output logic                          out_far
);

  localparam int CMPW = (EP_W > ssfe_pkg::R2_W) ? EP_W : ssfe_pkg::R2_W;

  logic [ssfe_pkg::R2_W-1:0] dd;
  logic                      far1;
  logic                      v1;

  // A point outside the radius contributes nothing; otherwise keep r^2 - R2.
  always_ff @(posedge clk) begin
    if (flags.perp) begin
      far1 <= flags.ovf || (quot > ssfe_pkg::DIST_Q_W'(r2));
      dd   <= r2 - quot[ssfe_pkg::R2_W-1:0];
    end else begin
      far1 <= (CMPW'(ep) > CMPW'(r2));
      dd   <= r2 - ssfe_pkg::R2_W'(ep);
    end
    dd_sq   <= ssfe_pkg::R4_W'(dd) * ssfe_pkg::R4_W'(dd);
    out_far <= far1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/core/segment_skeleton_field_eval_core.sv */
// Line-segment skeleton field evaluator.
// Software programs endpoint A, endpoint B and the radius through the APB
// port; registers sit at byte addresses 0, 4, ... 24 in the order end_a_x,
// end_a_y, end_a_z, end_b_x, end_b_y, end_b_z, radius. pready is always high
// and reads return the stored values. Software must write the registers only
// while no request is in flight; the block itself does not enforce this.
// A request is a query point on point_x/y/z, taken at a clock edge where
// start is high and busy is low. busy never rises, so one request can be
// taken every cycle and many are in flight at once.
// Each request yields exactly one result: field_value is shown for one cycle
// with done high. On its way the request passes the six geometry stages,
// the 31-stage distance divider, two falloff stages, the 17-stage
// normalizing divider and the output register.
// The receiver cannot stall the block; results leave in request order.
// Synchronous reset drops every request in flight and loads the default
// segment (origin to z = 256) and radius 77.
module segment_skeleton_field_eval_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [4:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic signed [COORD_WIDTH-1:0]         point_z,
  output logic                                  done,
  output logic [ssfe_pkg::FIELD_W-1:0]          field_value
);

  localparam int W    = COORD_WIDTH;
  localparam int SW   = 2 * W + 4;
  localparam int NW   = 4 * W + 8;
  localparam int FLW  = $bits(ssfe_pkg::geom_flags_t);
  localparam int N2_W = ssfe_pkg::R4_W + ssfe_pkg::FIELD_FRAC;

  // Configuration registers.
  logic signed [W-1:0]            end_a_x;
  logic signed [W-1:0]            end_a_y;
  logic signed [W-1:0]            end_a_z;
  logic signed [W-1:0]            end_b_x;
  logic signed [W-1:0]            end_b_y;
  logic signed [W-1:0]            end_b_z;
  logic [ssfe_pkg::RADIUS_W-1:0]  radius;

  // r^2 is registered from the radius register and r^4 from r^2, well before
  // any request reaches the stages that use them.
  logic [ssfe_pkg::R2_W-1:0] r2;
  logic [ssfe_pkg::R4_W-1:0] r4;

  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_a_x <= '0;
      end_a_y <= '0;
      end_a_z <= '0;
      end_b_x <= '0;
      end_b_y <= '0;
      end_b_z <= W'(256);
      radius  <= ssfe_pkg::RADIUS_W'(77);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ssfe_pkg::REG_END_A_X: begin
          end_a_x <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_END_A_Y: begin
          end_a_y <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_END_A_Z: begin
          end_a_z <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_END_B_X: begin
          end_b_x <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_END_B_Y: begin
          end_b_y <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_END_B_Z: begin
          end_b_z <= pwdata[W-1:0];
        end
        ssfe_pkg::REG_RADIUS: begin
          radius <= pwdata[ssfe_pkg::RADIUS_W-1:0];
        end
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ssfe_pkg::REG_END_A_X: prdata = 32'($unsigned(end_a_x));
      ssfe_pkg::REG_END_A_Y: prdata = 32'($unsigned(end_a_y));
      ssfe_pkg::REG_END_A_Z: prdata = 32'($unsigned(end_a_z));
      ssfe_pkg::REG_END_B_X: prdata = 32'($unsigned(end_b_x));
      ssfe_pkg::REG_END_B_Y: prdata = 32'($unsigned(end_b_y));
      ssfe_pkg::REG_END_B_Z: prdata = 32'($unsigned(end_b_z));
      ssfe_pkg::REG_RADIUS:  prdata = 32'(radius);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    r2 <= ssfe_pkg::R2_W'(radius) * ssfe_pkg::R2_W'(radius);
    r4 <= ssfe_pkg::R4_W'(r2) * ssfe_pkg::R4_W'(r2);
  end

  // Geometry front end: offsets, dot and cross products, and the choice
  // between the endpoint distances and the perpendicular one.
  logic                  g_valid;
  logic [NW-1:0]         g_csq;
  logic [SW-1:0]         g_len2;
  logic [SW-1:0]         g_ep;
  ssfe_pkg::geom_flags_t g_flags;

  ssfe_geom #(
    .COORD_WIDTH (W)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .px        (point_x),
    .py        (point_y),
    .pz        (point_z),
    .ax        (end_a_x),
    .ay        (end_a_y),
    .az        (end_a_z),
    .bx        (end_b_x),
    .by        (end_b_y),
    .bz        (end_b_z),
    .out_valid (g_valid),
    .out_csq   (g_csq),
    .out_len2  (g_len2),
    .out_ep    (g_ep),
    .out_flags (g_flags)
  );

  // Squared perpendicular distance: |AP x AB|^2 / |AB|^2, one quotient bit per stage.
  // The endpoint distance and the flags ride along beside the quotient.
  logic                          d1_valid;
  logic [ssfe_pkg::DIST_Q_W-1:0] d1_quot;
  logic [FLW+SW-1:0]             d1_side;
  ssfe_pkg::geom_flags_t         d1_flags;

  ssfe_div_pipe #(
    .NUM_W  (NW),
    .DEN_W  (SW),
    .Q_W    (ssfe_pkg::DIST_Q_W),
    .SIDE_W (FLW + SW)
  ) u_dist_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .num       (g_csq),
    .den       (g_len2),
    .side      ({g_flags, g_ep}),
    .out_valid (d1_valid),
    .quot      (d1_quot),
    .out_side  (d1_side)
  );

  assign d1_flags = ssfe_pkg::geom_flags_t'(d1_side[FLW+SW-1:SW]);

  // Falloff numerator (r^2 - R2)^2 and the out-of-range flag.
  logic                      f_valid;
  logic [ssfe_pkg::R4_W-1:0] f_dd_sq;
  logic                      f_far;

  ssfe_falloff #(
    .EP_W (SW)
  ) u_falloff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .quot      (d1_quot),
    .flags     (d1_flags),
    .ep        (d1_side[SW-1:0]),
    .r2        (r2),
    .out_valid (f_valid),
    .dd_sq     (f_dd_sq),
    .out_far   (f_far)
  );

  // Normalize by r^4 into Q0.16; within the radius the quotient reaches 65536 only at R2 = 0.
  logic                           d2_valid;
  logic [ssfe_pkg::FIELD_Q_W-1:0] d2_quot;
  logic                           d2_far;

  ssfe_div_pipe #(
    .NUM_W  (N2_W),
    .DEN_W  (ssfe_pkg::R4_W),
    .Q_W    (ssfe_pkg::FIELD_Q_W),
    .SIDE_W (1)
  ) u_field_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       ({f_dd_sq, ssfe_pkg::FIELD_FRAC'(0)}),
    .den       (r4),
    .side      (f_far),
    .out_valid (d2_valid),
    .quot      (d2_quot),
    .out_side  (d2_far)
  );

  // Output register. A zero radius forces zero, since r^4 is then zero too.
  always_ff @(posedge clk) begin
    if (d2_far || (r2 == '0)) begin
      field_value <= '0;
    end else if (d2_quot[ssfe_pkg::FIELD_Q_W-1]) begin
      field_value <= '1;
    end else begin
      field_value <= d2_quot[ssfe_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_valid;
    end
  end

`ifndef SYNTHESIS
  // Every request comes out after the fixed latency.
  a_req_to_result : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ssfe_pkg::PIPE_LAT) done)
    else $error("request did not produce a result after the pipeline latency");

  // No result appears without a request at the matching edge.
  a_result_has_req : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, ssfe_pkg::PIPE_LAT))
    else $error("result without a matching request");

  // With a zero radius every result is zero.
  a_zero_radius : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(d2_valid && (r2 == '0))) |-> (done && (field_value == '0)))
    else $error("nonzero field for a zero radius");
`endif

endmodule
